// ===== src/esc_pkg.sv =====
// Shared types, constants and helpers for the environmental sensor compensation block.
// No dependencies.
package esc_pkg;

   typedef enum logic [5:0] {
      ST_IDLE, ST_T0, ST_T1, ST_T2, ST_T3,
      ST_P0, ST_P1, ST_P2, ST_P3, ST_P4, ST_P5, ST_P6, ST_PN, ST_P7, ST_DIV,
      ST_P8, ST_P9, ST_P10, ST_PF,
      ST_H0, ST_H1, ST_H2, ST_H3, ST_H4, ST_H5, ST_H6, ST_H7, ST_H8,
      ST_OUT
   } state_type;

   localparam int CsrIdxWidth = 3;
   localparam logic [CsrIdxWidth-1:0] REG_TEMP_TRIM  = 3'd0;
   localparam logic [CsrIdxWidth-1:0] REG_PRESS_LOW  = 3'd1;
   localparam logic [CsrIdxWidth-1:0] REG_PRESS_MID  = 3'd2;
   localparam logic [CsrIdxWidth-1:0] REG_PRESS_HIGH = 3'd3;
   localparam logic [CsrIdxWidth-1:0] REG_HUM_LOW    = 3'd4;
   localparam logic [CsrIdxWidth-1:0] REG_HUM_HIGH   = 3'd5;

   localparam logic [19:0] TEMP_SKIP  = 20'h80000;
   localparam logic [19:0] PRESS_SKIP = 20'h80000;
   localparam logic [15:0] HUM_SKIP   = 16'h8000;
   localparam logic [31:0] HUM_MAX    = 32'd419430400;

   function automatic logic [63:0] sx16(input logic [15:0] x);
      return {{48{x[15]}}, x};
   endfunction

   function automatic logic [63:0] sx12(input logic [11:0] x);
      return {{52{x[11]}}, x};
   endfunction

   function automatic logic [63:0] sx8(input logic [7:0] x);
      return {{56{x[7]}}, x};
   endfunction

   function automatic logic [31:0] asr32(input logic [31:0] x, input logic [5:0] n);
      return 32'($signed(x) >>> n);
   endfunction

   function automatic logic [63:0] asr64(input logic [63:0] x, input logic [5:0] n);
      return 64'($signed(x) >>> n);
   endfunction

endpackage

// ===== src/esc_mul.sv =====
// Bit-serial 64x64 multiplier, low 64 bits of the product, one multiplier bit per cycle.
// Depends on nothing.
module esc_mul (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] op_a,
   input  logic [63:0] op_b,
   output logic        done,
   output logic [63:0] product
);
   logic [63:0] a_ff, a_in, b_ff, b_in, acc_ff, acc_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;

   always_comb begin
      a_in = a_ff;
      b_in = b_ff;
      acc_in = acc_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         a_in = op_a;
         b_in = op_b;
         acc_in = '0;
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (b_ff[0]) acc_in = acc_ff + a_ff;
         a_in = {a_ff[62:0], 1'b0};
         b_in = {1'b0, b_ff[63:1]};
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
      acc_ff <= acc_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign product = acc_ff;
endmodule

// ===== src/esc_div.sv =====
// Signed 64-bit restoring divider, one quotient bit per cycle, truncating toward zero.
// Depends on nothing. Divisor must be nonzero.
module esc_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [63:0] divisor,
   output logic        done,
   output logic [63:0] quotient
);
   logic [64:0] rem_ff, rem_in, rem_t;
   logic [63:0] quo_ff, quo_in, quo_t, dm_ff, dm_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        neg_ff, neg_in, busy_ff, busy_in, done_ff, done_in;

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      dm_in = dm_ff;
      neg_in = neg_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_t = {rem_ff[63:0], quo_ff[63]};
      quo_t = {quo_ff[62:0], 1'b0};
      if (rem_t >= {1'b0, dm_ff}) begin
         rem_t = rem_t - {1'b0, dm_ff};
         quo_t[0] = 1'b1;
      end
      if (start) begin
         // magnitudes as unsigned; the most negative value maps onto itself
         quo_in = dividend[63] ? -dividend : dividend;
         dm_in = divisor[63] ? -divisor : divisor;
         neg_in = dividend[63] ^ divisor[63];
         rem_in = '0;
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = rem_t;
         quo_in = quo_t;
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dm_ff <= dm_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quotient = neg_ff ? -quo_ff : quo_ff;
endmodule

// ===== src/env_sensor_compensation.sv =====
// Environmental sensor compensation: integer trimming of temperature, pressure, humidity.
// One item at a time; a run with all three fields measured takes 21 passes through the
// bit-serial multiplier and one 64-bit serial divide plus 6 single-state steps.
// Skipped fields shorten the run. The next item is taken in the cycle after the result is
// registered; the result waits in the last state while the output register is still held.
// Reset (synchronous) clears trim registers, fine temperature and the handshake state.
// Depends on esc_pkg, esc_mul, esc_div.
module env_sensor_compensation
   import esc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [19:0]            req_raw_temperature,
   input  logic [19:0]            req_raw_pressure,
   input  logic [15:0]            req_raw_humidity,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic signed [31:0]     rsp_temperature_centi,
   output logic signed [31:0]     rsp_pressure_q8,
   output logic [16:0]            rsp_humidity_q10,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CsrIdxWidth-1:0] csr_index,
   input  logic [47:0]            csr_wdata
);
   state_type   state_ff, state_in;
   logic [47:0] temp_trim_ff, press_low_ff, press_mid_ff, press_high_ff;
   logic [31:0] hum_low_ff, hum_high_ff;
   logic [19:0] raw_t_ff, raw_t_in, raw_p_ff, raw_p_in;
   logic [15:0] raw_h_ff, raw_h_in;
   logic [63:0] ta_ff, ta_in, tb_ff, tb_in, tc_ff, tc_in, td_ff, td_in;
   logic [31:0] ft_ff, ft_in, t_res_ff, t_res_in, p_res_ff, p_res_in;
   logic [16:0] h_res_ff, h_res_in;
   logic [31:0] o_t_ff, o_t_in, o_p_ff, o_p_in;
   logic [16:0] o_h_ff, o_h_in;
   logic        rsp_valid_ff, rsp_valid_in, issued_ff, issued_in;
   logic        mul_start, mul_done, div_start, div_done, is_mul;
   logic [63:0] mul_a, mul_b, prod, quo;
   logic [31:0] v32, ftn;
   logic [63:0] s64;
   state_type   after_t, after_p;

   esc_mul u_mul (
      .clock(clock), .reset(reset), .start(mul_start), .op_a(mul_a), .op_b(mul_b),
      .done(mul_done), .product(prod)
   );

   esc_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(tb_ff), .divisor(ta_ff),
      .done(div_done), .quotient(quo)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_temperature_centi = $signed(o_t_ff);
   assign rsp_pressure_q8 = $signed(o_p_ff);
   assign rsp_humidity_q10 = o_h_ff;

   always_comb begin
      after_p = (raw_h_ff == HUM_SKIP) ? ST_OUT : ST_H0;
      after_t = (raw_p_ff == PRESS_SKIP) ? after_p : ST_P0;
   end

   always_comb begin
      state_in = state_ff;
      raw_t_in = raw_t_ff;
      raw_p_in = raw_p_ff;
      raw_h_in = raw_h_ff;
      ta_in = ta_ff;
      tb_in = tb_ff;
      tc_in = tc_ff;
      td_in = td_ff;
      ft_in = ft_ff;
      t_res_in = t_res_ff;
      p_res_in = p_res_ff;
      h_res_in = h_res_ff;
      o_t_in = o_t_ff;
      o_p_in = o_p_ff;
      o_h_in = o_h_ff;
      rsp_valid_in = rsp_valid_ff;
      mul_a = ta_ff;
      mul_b = tb_ff;
      is_mul = 1'b0;
      div_start = 1'b0;
      v32 = '0;
      ftn = '0;
      s64 = '0;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               raw_t_in = req_raw_temperature;
               raw_p_in = req_raw_pressure;
               raw_h_in = req_raw_humidity;
               t_res_in = '0;
               p_res_in = '0;
               h_res_in = '0;
               state_in = ST_T0;
            end
         end
         ST_T0: begin
            if (raw_t_ff == TEMP_SKIP) begin
               state_in = after_t;
            end else begin
               ta_in = {32'd0, ({12'd0, raw_t_ff} >> 3) - {15'd0, temp_trim_ff[15:0], 1'b0}};
               tb_in = {32'd0, ({12'd0, raw_t_ff} >> 4) - {16'd0, temp_trim_ff[15:0]}};
               state_in = ST_T1;
            end
         end
         ST_T1: begin
            is_mul = 1'b1;
            mul_a = ta_ff;
            mul_b = sx16(temp_trim_ff[31:16]);
            if (mul_done) begin
               tc_in = {32'd0, asr32(prod[31:0], 6'd11)};
               state_in = ST_T2;
            end
         end
         ST_T2: begin
            is_mul = 1'b1;
            mul_a = tb_ff;
            mul_b = tb_ff;
            if (mul_done) begin
               tb_in = {32'd0, asr32(prod[31:0], 6'd12)};
               state_in = ST_T3;
            end
         end
         ST_T3: begin
            is_mul = 1'b1;
            mul_a = tb_ff;
            mul_b = sx16(temp_trim_ff[47:32]);
            if (mul_done) begin
               ftn = tc_ff[31:0] + asr32(prod[31:0], 6'd14);
               ft_in = ftn;
               t_res_in = asr32({ftn[29:0], 2'b00} + ftn + 32'd128, 6'd8);
               state_in = after_t;
            end
         end
         ST_P0: begin
            ta_in = {{32{ft_ff[31]}}, ft_ff} - 64'd128000;
            state_in = ST_P1;
         end
         ST_P1: begin
            is_mul = 1'b1;
            mul_a = ta_ff;
            mul_b = ta_ff;
            if (mul_done) begin
               tb_in = prod;
               state_in = ST_P2;
            end
         end
         ST_P2: begin
            is_mul = 1'b1;
            mul_a = tb_ff;
            mul_b = sx16(press_mid_ff[47:32]);
            if (mul_done) begin
               tc_in = prod;
               state_in = ST_P3;
            end
         end
         ST_P3: begin
            is_mul = 1'b1;
            mul_a = ta_ff;
            mul_b = sx16(press_mid_ff[31:16]);
            if (mul_done) begin
               tc_in = tc_ff + (prod << 17) + (sx16(press_mid_ff[15:0]) << 35);
               state_in = ST_P4;
            end
         end
         ST_P4: begin
            is_mul = 1'b1;
            mul_a = tb_ff;
            mul_b = sx16(press_low_ff[47:32]);
            if (mul_done) begin
               td_in = asr64(prod, 6'd8);
               state_in = ST_P5;
            end
         end
         ST_P5: begin
            is_mul = 1'b1;
            mul_a = ta_ff;
            mul_b = sx16(press_low_ff[31:16]);
            if (mul_done) begin
               td_in = td_ff + (prod << 12) + (64'd1 << 47);
               state_in = ST_P6;
            end
         end
         ST_P6: begin
            is_mul = 1'b1;
            mul_a = td_ff;
            mul_b = {48'd0, press_low_ff[15:0]};
            if (mul_done) begin
               s64 = asr64(prod, 6'd33);
               ta_in = s64;
               // zero divisor leaves the pressure result at 0
               state_in = (s64 == 64'd0) ? after_p : ST_PN;
            end
         end
         ST_PN: begin
            tb_in = ((64'd1048576 - {44'd0, raw_p_ff}) << 31) - tc_ff;
            state_in = ST_P7;
         end
         ST_P7: begin
            is_mul = 1'b1;
            mul_a = tb_ff;
            mul_b = 64'd3125;
            if (mul_done) begin
               tb_in = prod;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            div_start = !issued_ff;
            if (div_done) begin
               tb_in = quo;
               tc_in = asr64(quo, 6'd13);
               state_in = ST_P8;
            end
         end
         ST_P8: begin
            is_mul = 1'b1;
            mul_a = sx16(press_high_ff[47:32]);
            mul_b = tc_ff;
            if (mul_done) begin
               td_in = prod;
               state_in = ST_P9;
            end
         end
         ST_P9: begin
            is_mul = 1'b1;
            mul_a = td_ff;
            mul_b = tc_ff;
            if (mul_done) begin
               td_in = asr64(prod, 6'd25);
               state_in = ST_P10;
            end
         end
         ST_P10: begin
            is_mul = 1'b1;
            mul_a = sx16(press_high_ff[31:16]);
            mul_b = tb_ff;
            if (mul_done) begin
               tc_in = asr64(prod, 6'd19);
               state_in = ST_PF;
            end
         end
         ST_PF: begin
            s64 = asr64(tb_ff + td_ff + tc_ff, 6'd8) + (sx16(press_high_ff[15:0]) << 4);
            p_res_in = s64[31:0];
            state_in = after_p;
         end
         ST_H0: begin
            ta_in = {32'd0, ft_ff - 32'd76800};
            state_in = ST_H1;
         end
         ST_H1: begin
            is_mul = 1'b1;
            mul_a = ta_ff;
            mul_b = sx12(hum_high_ff[23:12]);
            if (mul_done) begin
               v32 = {2'b00, raw_h_ff, 14'd0} - {hum_high_ff[11:0], 20'd0} - prod[31:0]
                     + 32'd16384;
               tb_in = {32'd0, asr32(v32, 6'd15)};
               state_in = ST_H2;
            end
         end
         ST_H2: begin
            is_mul = 1'b1;
            mul_a = ta_ff;
            mul_b = sx8(hum_high_ff[31:24]);
            if (mul_done) begin
               tc_in = {32'd0, asr32(prod[31:0], 6'd10)};
               state_in = ST_H3;
            end
         end
         ST_H3: begin
            is_mul = 1'b1;
            mul_a = ta_ff;
            mul_b = {56'd0, hum_low_ff[31:24]};
            if (mul_done) begin
               td_in = {32'd0, asr32(prod[31:0], 6'd11) + 32'd32768};
               state_in = ST_H4;
            end
         end
         ST_H4: begin
            is_mul = 1'b1;
            mul_a = tc_ff;
            mul_b = td_ff;
            if (mul_done) begin
               tc_in = {32'd0, asr32(prod[31:0], 6'd10) + 32'd2097152};
               state_in = ST_H5;
            end
         end
         ST_H5: begin
            is_mul = 1'b1;
            mul_a = tc_ff;
            mul_b = sx16(hum_low_ff[23:8]);
            if (mul_done) begin
               tc_in = {32'd0, asr32(prod[31:0] + 32'd8192, 6'd14)};
               state_in = ST_H6;
            end
         end
         ST_H6: begin
            is_mul = 1'b1;
            mul_a = tb_ff;
            mul_b = tc_ff;
            if (mul_done) begin
               ta_in = {32'd0, prod[31:0]};
               td_in = {32'd0, asr32(prod[31:0], 6'd15)};
               state_in = ST_H7;
            end
         end
         ST_H7: begin
            is_mul = 1'b1;
            mul_a = td_ff;
            mul_b = td_ff;
            if (mul_done) begin
               td_in = {32'd0, asr32(prod[31:0], 6'd7)};
               state_in = ST_H8;
            end
         end
         ST_H8: begin
            is_mul = 1'b1;
            mul_a = td_ff;
            mul_b = {56'd0, hum_low_ff[7:0]};
            if (mul_done) begin
               v32 = ta_ff[31:0] - asr32(prod[31:0], 6'd4);
               if (v32[31]) v32 = '0;
               else if (v32 > HUM_MAX) v32 = HUM_MAX;
               h_res_in = v32[28:12];
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            // output register must be free or emptying this cycle
            if (!rsp_valid_ff || rsp_ready) begin
               o_t_in = t_res_ff;
               o_p_in = p_res_ff;
               o_h_in = h_res_ff;
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      mul_start = is_mul && !issued_ff;
      if (mul_start || div_start) issued_in = 1'b1;
      else if (mul_done || div_done) issued_in = 1'b0;
      else issued_in = issued_ff;
   end

   always_ff @(posedge clock) begin
      raw_t_ff <= raw_t_in;
      raw_p_ff <= raw_p_in;
      raw_h_ff <= raw_h_in;
      ta_ff <= ta_in;
      tb_ff <= tb_in;
      tc_ff <= tc_in;
      td_ff <= td_in;
      t_res_ff <= t_res_in;
      p_res_ff <= p_res_in;
      h_res_ff <= h_res_in;
      o_t_ff <= o_t_in;
      o_p_ff <= o_p_in;
      o_h_ff <= o_h_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         issued_ff <= 1'b0;
         ft_ff <= '0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         issued_ff <= issued_in;
         ft_ff <= ft_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_trim_ff <= '0;
         press_low_ff <= '0;
         press_mid_ff <= '0;
         press_high_ff <= '0;
         hum_low_ff <= '0;
         hum_high_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_TEMP_TRIM:  temp_trim_ff <= csr_wdata;
            REG_PRESS_LOW:  press_low_ff <= csr_wdata;
            REG_PRESS_MID:  press_mid_ff <= csr_wdata;
            REG_PRESS_HIGH: press_high_ff <= csr_wdata;
            REG_HUM_LOW:    hum_low_ff <= csr_wdata[31:0];
            REG_HUM_HIGH:   hum_high_ff <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end
endmodule
